### hdl/midi_event_playback_scheduler_macros.svh
// Assertion macros for the playback scheduler.
`ifndef MIDI_EVENT_PLAYBACK_SCHEDULER_MACROS_SVH
`define MIDI_EVENT_PLAYBACK_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MEPB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MEPB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/mepb_pkg.sv
// Shared constants, codes and divider interface types for the playback scheduler.
package mepb_pkg;

    localparam int EVENT_DEPTH_DEF       = 1024;
    localparam int MAX_EVENTS_DEF        = 63;
    localparam int MAX_BLOCK_SAMPLES_DEF = 8192;

    localparam logic [31:0] US_PER_S  = 32'd1000000;
    localparam logic [16:0] FRAC_ONE  = 17'h10000;
    localparam logic [8:0]  TEMPO_MIN = 9'd20;
    localparam logic [8:0]  TEMPO_MAX = 9'd300;

    localparam logic [17:0] SAMPLE_RATE_RST = 18'd48000;
    localparam logic [8:0]  TEMPO_RST       = 9'd120;
    localparam logic [9:0]  ORIG_BPM_RST    = 10'd120;

    localparam int DIV_STEPS = 64;

    typedef enum logic [2:0] {
        ACT_LOAD,
        ACT_BLOCK,
        ACT_PLAY,
        ACT_PAUSE,
        ACT_STOP,
        ACT_SEEK
    } t_action;

    typedef enum logic [2:0] {
        REG_SAMPLE_RATE,
        REG_TEMPO_BPM,
        REG_ORIGINAL_BPM,
        REG_SONG_LENGTH,
        REG_LOOPING,
        REG_EVENT_COUNT
    } t_reg_idx;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } t_div_rsp;

endpackage

### hdl/midi_event_playback_scheduler.sv
// MIDI event playback scheduler: top level with event store, sequencer and result buffer.
//
// Input beats (s_axis) carry one command each, the action code in tuser. Load beats
// write one event into the store; play, pause, stop change the transport; seek moves
// the playhead and scans the store for the first event at or after it; a running block beat
// advances the playhead by one audio block and collects the non-meta events in that window.
// Every command answers with zero or more event beats (tuser = 1) and one status beat
// (tuser = 0, tlast = 1). Overflow and position are known only after the whole walk,
// so events are buffered and replayed after the walk finishes.
// One shared 32x32 multiplier and one 64-step serial divider do all the arithmetic.
// With the output always ready, a plain command runs from accept through the position
// divide (skipped if the song length is zero) to its status beat. A running block adds
// the multiplies, the duration divide and the wrap-up, a read of each store entry walked,
// an offset divide for each event in the window and the event beats.
// A seek adds its multiply and a read of each entry scanned.
// s_axis_tready is high only between commands. Stalling the output just holds the
// sequencer. Reset stops the transport, zeroes playhead and walk index and loads the
// register defaults; the event store is not cleared.
// Config (APB) writes are expected only between commands.
`include "midi_event_playback_scheduler_macros.svh"

module midi_event_playback_scheduler #(
    parameter int EVENT_DEPTH          = mepb_pkg::EVENT_DEPTH_DEF,
    parameter int MAX_EVENTS_PER_BLOCK = mepb_pkg::MAX_EVENTS_DEF,
    parameter int MAX_BLOCK_SAMPLES    = mepb_pkg::MAX_BLOCK_SAMPLES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slot[9:0], event_time_us[41:10], message_bytes[65:42], is_meta[66],
    // block_samples[80:67], seek_fraction[97:81], zero pad [103:98]
    input  logic [103:0] s_axis_tdata,
    // action[2:0]
    input  logic [2:0]   s_axis_tuser,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // out_message[23:0], sample_offset[36:24], is_playing[37], position[54:38],
    // overflow[55]
    output logic [55:0]  m_axis_tdata,
    // event_valid[0]
    output logic         m_axis_tuser,
    output logic         m_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
    localparam int NW = $clog2(MAX_EVENTS_PER_BLOCK + 1);
    localparam int BW = (MAX_EVENTS_PER_BLOCK > 1) ? $clog2(MAX_EVENTS_PER_BLOCK) : 1;

    typedef struct packed {
        logic        meta;
        logic [23:0] msg;
        logic [31:0] tm;
    } t_evt;

    typedef struct packed {
        logic [23:0] msg;
        logic [12:0] offs;
    } t_emit;

    typedef enum logic [4:0] {
        S_IDLE, S_M1, S_M2, S_M3, S_M4, S_DUR,
        S_W_CHK, S_W_RD, S_W_OM, S_W_OD, S_W_FIN,
        S_SK_M, S_SK_T, S_SK_CHK, S_SK_RD,
        S_POS, S_POS_W, S_E_CHK, S_E_LD, S_E_WT
    } t_state;

    // ---- configuration registers
    logic [17:0] r_sample_rate;
    logic [8:0]  r_tempo;
    logic [9:0]  r_orig_bpm;
    logic [31:0] r_len;
    logic        r_loop;
    logic [10:0] r_count;

    logic                   cfg_wr;
    mepb_pkg::t_reg_idx     cfg_idx;

    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = mepb_pkg::t_reg_idx'(paddr[4:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= mepb_pkg::SAMPLE_RATE_RST;
            r_tempo       <= mepb_pkg::TEMPO_RST;
            r_orig_bpm    <= mepb_pkg::ORIG_BPM_RST;
            r_len         <= '0;
            r_loop        <= 1'b0;
            r_count       <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                mepb_pkg::REG_SAMPLE_RATE:  r_sample_rate <= pwdata[17:0];
                mepb_pkg::REG_TEMPO_BPM: begin
                    if (pwdata[8:0] < mepb_pkg::TEMPO_MIN)      r_tempo <= mepb_pkg::TEMPO_MIN;
                    else if (pwdata[8:0] > mepb_pkg::TEMPO_MAX) r_tempo <= mepb_pkg::TEMPO_MAX;
                    else                                        r_tempo <= pwdata[8:0];
                end
                mepb_pkg::REG_ORIGINAL_BPM: r_orig_bpm <= pwdata[9:0];
                mepb_pkg::REG_SONG_LENGTH:  r_len      <= pwdata;
                mepb_pkg::REG_LOOPING:      r_loop     <= pwdata[0];
                mepb_pkg::REG_EVENT_COUNT: begin
                    if (32'(pwdata[10:0]) > 32'(EVENT_DEPTH)) r_count <= 11'(EVENT_DEPTH);
                    else                                      r_count <= pwdata[10:0];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            mepb_pkg::REG_SAMPLE_RATE:  prdata = 32'(r_sample_rate);
            mepb_pkg::REG_TEMPO_BPM:    prdata = 32'(r_tempo);
            mepb_pkg::REG_ORIGINAL_BPM: prdata = 32'(r_orig_bpm);
            mepb_pkg::REG_SONG_LENGTH:  prdata = r_len;
            mepb_pkg::REG_LOOPING:      prdata = 32'(r_loop);
            mepb_pkg::REG_EVENT_COUNT:  prdata = 32'(r_count);
            default:                    prdata = '0;
        endcase
    end

    // ---- input beat decode
    logic        in_acc;
    logic [9:0]  in_slot;
    logic [13:0] in_ns;
    logic [16:0] in_frac;
    logic [16:0] ns_eff;
    logic [16:0] frac_eff;
    t_evt        in_evt;

    assign in_acc   = s_axis_tvalid & s_axis_tready;
    assign in_slot  = s_axis_tdata[9:0];
    assign in_ns    = s_axis_tdata[80:67];
    assign in_frac  = s_axis_tdata[97:81];
    assign in_evt   = '{meta: s_axis_tdata[66], msg: s_axis_tdata[65:42],
                        tm: s_axis_tdata[41:10]};

    always_comb begin
        if (in_ns == '0)                                 ns_eff = 17'd1;
        else if (32'(in_ns) > 32'(MAX_BLOCK_SAMPLES))    ns_eff = 17'(MAX_BLOCK_SAMPLES);
        else                                             ns_eff = 17'(in_ns);
        frac_eff = (in_frac > mepb_pkg::FRAC_ONE) ? mepb_pkg::FRAC_ONE : in_frac;
    end

    // ---- sequencer registers
    t_state      r_state;
    logic [31:0] r_playhead;
    logic [10:0] r_next;
    logic        r_running;
    logic [16:0] r_ns;
    logic [16:0] r_frac;
    logic [31:0] r_tbus;     // tempo * 1e6, offset divisor
    logic [31:0] r_sob;      // sample_rate * original_bpm
    logic [63:0] r_num;
    logic [63:0] r_end;
    logic [63:0] r_prod;
    logic [23:0] r_msg;
    logic [NW-1:0] r_n;
    logic [NW-1:0] r_eidx;
    logic        r_ovf;
    logic [16:0] r_pos;
    logic [55:0] r_o_data;
    logic        r_o_user;
    logic        r_o_last;
    logic        r_o_valid;

    // ---- event store
    t_evt        mem [EVENT_DEPTH];
    t_evt        r_rd;
    logic [AW-1:0] rd_addr;
    logic        st_wr;

    assign rd_addr = AW'(r_next);
    assign st_wr   = in_acc && (mepb_pkg::t_action'(s_axis_tuser) == mepb_pkg::ACT_LOAD)
                     && (32'(in_slot) < 32'(EVENT_DEPTH));

    always_ff @(posedge i_clk) begin
        if (st_wr) begin
            mem[AW'(in_slot)] <= in_evt;
        end
        r_rd <= mem[rd_addr];
    end

    // ---- shared multiplier, 32x32 with registered product
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [17:0] sr_eff;
    logic [9:0]  ob_eff;

    assign sr_eff = (r_sample_rate == '0) ? 18'd1 : r_sample_rate;
    assign ob_eff = (r_orig_bpm == '0) ? 10'd1 : r_orig_bpm;

    always_comb begin
        case (r_state)
            S_M1: begin
                mul_a = 32'(r_tempo);
                mul_b = mepb_pkg::US_PER_S;
            end
            S_M2: begin
                mul_a = r_prod[31:0];
                mul_b = 32'(r_ns);
            end
            S_M3: begin
                mul_a = 32'(sr_eff);
                mul_b = 32'(ob_eff);
            end
            S_W_RD: begin
                mul_a = r_rd.tm - r_playhead;
                mul_b = r_sob;
            end
            S_SK_M: begin
                mul_a = 32'(r_frac);
                mul_b = r_len;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
    end

    // ---- shared divider
    mepb_pkg::t_div_req div_req;
    mepb_pkg::t_div_rsp div_rsp;

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = r_num;
        div_req.divisor  = r_prod[31:0];
        case (r_state)
            S_M4: begin
                div_req.start = 1'b1;
            end
            S_W_OM: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_prod;
                div_req.divisor  = r_tbus;
            end
            S_POS: begin
                div_req.start    = (r_len != '0);
                div_req.dividend = {16'b0, r_playhead, 16'b0};
                div_req.divisor  = r_len;
            end
            default: ;
        endcase
    end

    mepb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ---- offset clamp to the block
    logic [63:0] ns_m1;
    logic [12:0] offs_c;

    assign ns_m1  = 64'(r_ns - 17'd1);
    assign offs_c = (div_rsp.quot > ns_m1) ? ns_m1[12:0] : div_rsp.quot[12:0];

    // ---- emitted-event buffer, replayed after the walk
    t_emit ebuf [MAX_EVENTS_PER_BLOCK];
    t_emit r_bq;
    logic  buf_wr;

    assign buf_wr = (r_state == S_W_OD) && div_rsp.done
                    && (32'(r_n) < 32'(MAX_EVENTS_PER_BLOCK));

    always_ff @(posedge i_clk) begin
        if (buf_wr) begin
            ebuf[BW'(r_n)] <= '{msg: r_msg, offs: offs_c};
        end
        r_bq <= ebuf[BW'(r_eidx)];
    end

    // ---- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_playhead <= '0;
            r_next     <= '0;
            r_running  <= 1'b0;
            r_o_valid  <= 1'b0;
            r_n        <= '0;
            r_eidx     <= '0;
            r_ovf      <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_n    <= '0;
                        r_eidx <= '0;
                        r_ovf  <= 1'b0;
                        r_ns   <= ns_eff;
                        r_frac <= frac_eff;
                        case (mepb_pkg::t_action'(s_axis_tuser))
                            mepb_pkg::ACT_BLOCK: begin
                                // idle block: stopped or empty store changes nothing
                                r_state <= (r_running && r_count != '0) ? S_M1 : S_POS;
                            end
                            mepb_pkg::ACT_PLAY: begin
                                r_running <= 1'b1;
                                r_state   <= S_POS;
                            end
                            mepb_pkg::ACT_PAUSE: begin
                                r_running <= 1'b0;
                                r_state   <= S_POS;
                            end
                            mepb_pkg::ACT_STOP: begin
                                r_running  <= 1'b0;
                                r_playhead <= '0;
                                r_next     <= '0;
                                r_state    <= S_POS;
                            end
                            mepb_pkg::ACT_SEEK:  r_state <= S_SK_M;
                            default:             r_state <= S_POS;
                        endcase
                    end
                end
                S_M1: r_state <= S_M2;
                S_M2: begin
                    r_tbus  <= r_prod[31:0];
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_num   <= r_prod;
                    r_state <= S_M4;
                end
                S_M4: begin
                    r_sob   <= r_prod[31:0];
                    r_state <= S_DUR;
                end
                S_DUR: begin
                    if (div_rsp.done) begin
                        r_end   <= 64'(r_playhead) + div_rsp.quot;
                        r_state <= S_W_CHK;
                    end
                end
                S_W_CHK: begin
                    r_state <= (r_next < r_count) ? S_W_RD : S_W_FIN;
                end
                S_W_RD: begin
                    if (64'(r_rd.tm) >= r_end) begin
                        r_state <= S_W_FIN;
                    end else if (r_rd.tm >= r_playhead && !r_rd.meta) begin
                        r_msg   <= r_rd.msg;
                        r_state <= S_W_OM;
                    end else begin
                        r_next  <= r_next + 1'b1;
                        r_state <= S_W_CHK;
                    end
                end
                S_W_OM: r_state <= S_W_OD;
                S_W_OD: begin
                    if (div_rsp.done) begin
                        if (buf_wr) r_n   <= r_n + 1'b1;
                        else        r_ovf <= 1'b1;
                        r_next  <= r_next + 1'b1;
                        r_state <= S_W_CHK;
                    end
                end
                S_W_FIN: begin
                    if (r_end >= 64'(r_len)) begin
                        r_playhead <= '0;
                        r_next     <= '0;
                        if (!r_loop) r_running <= 1'b0;
                    end else begin
                        r_playhead <= r_end[31:0];
                    end
                    r_state <= S_POS;
                end
                S_SK_M: r_state <= S_SK_T;
                S_SK_T: begin
                    r_playhead <= r_prod[47:16];
                    r_next     <= '0;
                    r_state    <= S_SK_CHK;
                end
                // scan leaves r_next at the hit, or at the count if none
                S_SK_CHK: begin
                    r_state <= (r_next < r_count) ? S_SK_RD : S_POS;
                end
                S_SK_RD: begin
                    if (r_rd.tm >= r_playhead) begin
                        r_state <= S_POS;
                    end else begin
                        r_next  <= r_next + 1'b1;
                        r_state <= S_SK_CHK;
                    end
                end
                S_POS: begin
                    if (r_len == '0) begin
                        r_pos   <= '0;
                        r_state <= S_E_CHK;
                    end else begin
                        r_state <= S_POS_W;
                    end
                end
                S_POS_W: begin
                    if (div_rsp.done) begin
                        r_pos   <= (div_rsp.quot > 64'(mepb_pkg::FRAC_ONE))
                                   ? mepb_pkg::FRAC_ONE : div_rsp.quot[16:0];
                        r_state <= S_E_CHK;
                    end
                end
                S_E_CHK: begin
                    if (r_eidx < r_n) begin
                        r_state <= S_E_LD;
                    end else begin
                        r_o_data  <= {r_ovf, r_pos, r_running, 13'b0, 24'b0};
                        r_o_user  <= 1'b0;
                        r_o_last  <= 1'b1;
                        r_o_valid <= 1'b1;
                        r_state   <= S_E_WT;
                    end
                end
                S_E_LD: begin
                    r_o_data  <= {r_ovf, r_pos, r_running, r_bq.offs, r_bq.msg};
                    r_o_user  <= 1'b1;
                    r_o_last  <= 1'b0;
                    r_o_valid <= 1'b1;
                    r_state   <= S_E_WT;
                end
                S_E_WT: begin
                    if (m_axis_tready) begin
                        r_o_valid <= 1'b0;
                        if (r_o_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_eidx  <= r_eidx + 1'b1;
                            r_state <= S_E_CHK;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_user;
    assign m_axis_tlast  = r_o_last;

    // ---- checks
    `MEPB_ASSERT_NOW(a_no_overlap, m_axis_tvalid, !s_axis_tready,
        "input accepted while a result beat is pending")
    `MEPB_ASSERT_NEXT(a_last_frees, m_axis_tvalid && m_axis_tready && m_axis_tlast,
        s_axis_tready, "block not ready after the status beat")
    `MEPB_ASSERT_NOW(a_buf_bound, 1'b1, 32'(r_n) <= 32'(MAX_EVENTS_PER_BLOCK),
        "event buffer fill beyond limit")
    `MEPB_ASSERT_NOW(a_evt_not_last, m_axis_tvalid && m_axis_tuser, !m_axis_tlast,
        "event beat marked last")

endmodule

### hdl/mepb_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
module mepb_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mepb_pkg::t_div_req  i_req,
    output mepb_pkg::t_div_rsp  o_rsp
);

    localparam int CW = $clog2(mepb_pkg::DIV_STEPS);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [31:0]   r_rem;
    logic [31:0]   r_den;
    logic [63:0]   r_q;

    logic [32:0]   trial;
    logic          fits;
    logic [31:0]   n_rem;

    always_comb begin
        trial = {r_rem, r_q[63]};
        fits  = trial >= {1'b0, r_den};
        n_rem = fits ? 32'(trial - {1'b0, r_den}) : trial[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // done pulses for one cycle after the last quotient bit
            r_done <= !i_req.start && r_busy && (r_cnt == CW'(mepb_pkg::DIV_STEPS - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_den  <= i_req.divisor;
                r_q    <= i_req.dividend;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_q   <= {r_q[62:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(mepb_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the MIDI event playback scheduler.
module tb_top;

    // Action codes outside the enum; the block must treat them as no-ops.
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 20_000_000;
    localparam int unsigned PHASE_ITEMS = 15;

    typedef struct packed {
        logic [2:0]  act;
        logic [9:0]  slot;
        logic [31:0] ev_us;
        logic [23:0] msg;
        logic        meta;
        logic [13:0] ns;
        logic [16:0] frac;
    } t_cmd;

    typedef struct packed {
        logic        valid;
        logic [23:0] msg;
        logic [12:0] offs;
        logic        last;
        logic        playing;
        logic [16:0] pos;
        logic        ovf;
    } t_beat;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic [103:0]  s_axis_tdata = '0;
    logic [2:0]    s_axis_tuser = '0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [55:0]   m_axis_tdata;
    logic          m_axis_tuser;
    logic          m_axis_tlast;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [4:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    midi_event_playback_scheduler u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Scoreboard model: event store, transport and register copies
    // ---------------------------------------------------------------
    logic [31:0] st_time [0:1023];
    logic [23:0] st_msg  [0:1023];
    logic        st_meta [0:1023];
    logic [31:0] ph_us = '0;
    int unsigned walk_idx = 0;
    bit          transport_on = 1'b0;

    int unsigned cfg_rate = 48000;
    int unsigned cfg_tempo = 120;
    int unsigned cfg_orig = 120;
    logic [31:0] cfg_len = '0;
    bit          cfg_loop = 1'b0;
    int unsigned cfg_count = 0;

    t_beat       expected_beats [$];
    t_cmd        pending_cmds [$];
    int unsigned issued_cmds = 0;
    int unsigned finished_cmds = 0;
    int unsigned mismatch_count = 0;
    bit          calm_mode = 1'b0;

    function automatic logic [16:0] playhead_fraction();
        longint unsigned p;
        if (cfg_len == 0) return '0;
        p = (64'(ph_us) * 64'd65536) / 64'(cfg_len);
        return (p > 64'd65536) ? 17'h10000 : p[16:0];
    endfunction

    // Update the model with one accepted command and queue its beats.
    task automatic schedule_item(t_cmd c);
        longint unsigned ns, sr, ob, tb, cur, dur, fin, t, off, f, target;
        logic [23:0] ev_msgs [$];
        logic [12:0] ev_offs [$];
        bit ovf;
        t_beat b;
        ovf = 1'b0;
        case (c.act)
            mepb_pkg::ACT_LOAD: begin
                st_time[c.slot] = c.ev_us;
                st_msg[c.slot]  = c.msg;
                st_meta[c.slot] = c.meta;
            end
            mepb_pkg::ACT_BLOCK: begin
                if (transport_on && cfg_count != 0) begin
                    ns = 64'(c.ns);
                    if (ns == 0) ns = 64'd1;
                    if (ns > 64'(mepb_pkg::MAX_BLOCK_SAMPLES_DEF))
                        ns = 64'(mepb_pkg::MAX_BLOCK_SAMPLES_DEF);
                    sr = (cfg_rate == 0) ? 64'd1 : 64'(cfg_rate);
                    ob = (cfg_orig == 0) ? 64'd1 : 64'(cfg_orig);
                    tb = 64'(cfg_tempo);
                    cur = 64'(ph_us);
                    dur = (ns * 64'd1000000 * tb) / (sr * ob);
                    fin = cur + dur;
                    while (walk_idx < cfg_count) begin
                        t = 64'(st_time[walk_idx]);
                        if (t >= fin) break;
                        if (t >= cur && !st_meta[walk_idx]) begin
                            off = ((t - cur) * ob * sr) / (tb * 64'd1000000);
                            if (off > ns - 1) off = ns - 1;
                            if (ev_msgs.size() < mepb_pkg::MAX_EVENTS_DEF) begin
                                ev_msgs.insert(ev_msgs.size(), st_msg[walk_idx]);
                                ev_offs.insert(ev_offs.size(), off[12:0]);
                            end else begin
                                ovf = 1'b1;
                            end
                        end
                        walk_idx++;
                    end
                    if (fin >= 64'(cfg_len)) begin
                        // song end: rewind, stop unless looping
                        ph_us = '0;
                        walk_idx = 0;
                        if (!cfg_loop) transport_on = 1'b0;
                    end else begin
                        ph_us = fin[31:0];
                    end
                end
            end
            mepb_pkg::ACT_PLAY:  transport_on = 1'b1;
            mepb_pkg::ACT_PAUSE: transport_on = 1'b0;
            mepb_pkg::ACT_STOP: begin
                transport_on = 1'b0;
                ph_us = '0;
                walk_idx = 0;
            end
            mepb_pkg::ACT_SEEK: begin
                f = 64'(c.frac);
                if (f > 64'd65536) f = 64'd65536;
                target = (f * 64'(cfg_len)) / 64'd65536;
                ph_us = target[31:0];
                walk_idx = cfg_count;
                for (int unsigned k = 0; k < cfg_count; k++) begin
                    if (64'(st_time[k]) >= target) begin
                        walk_idx = k;
                        break;
                    end
                end
            end
            default: ;
        endcase
        b.playing = transport_on;
        b.pos = playhead_fraction();
        b.ovf = ovf;
        foreach (ev_msgs[i]) begin
            b.valid = 1'b1;
            b.msg = ev_msgs[i];
            b.offs = ev_offs[i];
            b.last = 1'b0;
            expected_beats.insert(expected_beats.size(), b);
        end
        b.valid = 1'b0;
        b.msg = '0;
        b.offs = '0;
        b.last = 1'b1;
        expected_beats.insert(expected_beats.size(), b);
    endtask

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------------------------------------------------------
    // Input driver
    // ---------------------------------------------------------------
    t_cmd        drv_cmd;
    int unsigned drv_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            drv_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) schedule_item(drv_cmd);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (drv_gap != 0) begin
                    drv_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    drv_cmd = pending_cmds.pop_front();
                    s_axis_tdata <= {6'd0, drv_cmd.frac, drv_cmd.ns, drv_cmd.meta,
                                     drv_cmd.msg, drv_cmd.ev_us, drv_cmd.slot};
                    s_axis_tuser <= drv_cmd.act;
                    s_axis_tvalid <= 1'b1;
                    drv_gap = pick_gap(calm_mode);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Output monitor and checker
    // ---------------------------------------------------------------
    int unsigned mon_stall = 0;

    always @(posedge i_clk) begin
        t_beat got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.valid   = m_axis_tuser;
                got.msg     = m_axis_tdata[23:0];
                got.offs    = m_axis_tdata[36:24];
                got.playing = m_axis_tdata[37];
                got.pos     = m_axis_tdata[54:38];
                got.ovf     = m_axis_tdata[55];
                got.last    = m_axis_tlast;
                if (got.last) finished_cmds++;
                if (expected_beats.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected beat: ev=%0b msg=%06h off=%0d last=%0b",
                                 got.valid, got.msg, got.offs, got.last);
                end else begin
                    want = expected_beats.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display({"beat mismatch exp: ev=%0b msg=%06h off=%0d",
                                      " last=%0b play=%0b pos=%0d ovf=%0b"},
                                     want.valid, want.msg, want.offs, want.last,
                                     want.playing, want.pos, want.ovf);
                            $display({"             got: ev=%0b msg=%06h off=%0d",
                                      " last=%0b play=%0b pos=%0d ovf=%0b"},
                                     got.valid, got.msg, got.offs, got.last,
                                     got.playing, got.pos, got.ovf);
                        end
                    end
                end
                mon_stall = pick_gap(calm_mode);
            end else if (mon_stall != 0) begin
                mon_stall--;
            end
            m_axis_tready <= (mon_stall == 0);
        end
    end

    // Watchdog
    int unsigned cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic write_reg(mepb_pkg::t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            mepb_pkg::REG_SAMPLE_RATE:  cfg_rate = 32'(val[17:0]);
            mepb_pkg::REG_TEMPO_BPM: begin
                if (val[8:0] < mepb_pkg::TEMPO_MIN)      cfg_tempo = 32'(mepb_pkg::TEMPO_MIN);
                else if (val[8:0] > mepb_pkg::TEMPO_MAX) cfg_tempo = 32'(mepb_pkg::TEMPO_MAX);
                else                                     cfg_tempo = 32'(val[8:0]);
            end
            mepb_pkg::REG_ORIGINAL_BPM: cfg_orig = 32'(val[9:0]);
            mepb_pkg::REG_SONG_LENGTH:  cfg_len = val;
            mepb_pkg::REG_LOOPING:      cfg_loop = val[0];
            mepb_pkg::REG_EVENT_COUNT: begin
                if (32'(val[10:0]) > 32'(mepb_pkg::EVENT_DEPTH_DEF))
                    cfg_count = 32'(mepb_pkg::EVENT_DEPTH_DEF);
                else
                    cfg_count = 32'(val[10:0]);
            end
            default: ;
        endcase
    endtask

    // Unused fields carry random noise; the block must ignore them.
    function automatic t_cmd noise_cmd(logic [2:0] act);
        t_cmd c;
        c.act   = act;
        c.slot  = 10'($urandom);
        c.ev_us = $urandom;
        c.msg   = 24'($urandom);
        c.meta  = 1'($urandom);
        c.ns    = 14'($urandom);
        c.frac  = 17'($urandom);
        return c;
    endfunction

    task automatic queue_cmd(t_cmd c);
        pending_cmds.insert(pending_cmds.size(), c);
        issued_cmds++;
    endtask

    task automatic queue_load(int unsigned slot, longint unsigned t, bit meta);
        t_cmd c;
        c = noise_cmd(mepb_pkg::ACT_LOAD);
        c.slot = 10'(slot);
        c.ev_us = 32'(t);
        c.meta = meta;
        queue_cmd(c);
    endtask

    task automatic queue_block(logic [13:0] ns);
        t_cmd c;
        c = noise_cmd(mepb_pkg::ACT_BLOCK);
        c.ns = ns;
        queue_cmd(c);
    endtask

    task automatic queue_seek(logic [16:0] frac);
        t_cmd c;
        c = noise_cmd(mepb_pkg::ACT_SEEK);
        c.frac = frac;
        queue_cmd(c);
    endtask

    // Sorted event times spread over [0, span); a few meta entries.
    task automatic load_sorted(int unsigned n, longint unsigned span);
        longint unsigned step;
        step = span / 64'(n);
        for (int unsigned k = 0; k < n; k++)
            queue_load(k, 64'(k) * step +
                          ((step > 1) ? 64'($urandom_range(32'(step - 1))) : 64'd0),
                       ($urandom_range(9) == 0));
    endtask

    task automatic wait_idle();
        do @(negedge i_clk); while (finished_cmds != issued_cmds);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [13:0] random_block_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80) return 14'($urandom_range(1, 1024));
        if (r < 90) return ($urandom_range(1) != 0) ? 14'd0
                                                    : 14'($urandom_range(8192, 16383));
        return 14'($urandom);
    endfunction

    initial begin
        int unsigned rate_tab [8] = '{48000, 48000, 8000, 192000, 0, 262143, 44100, 96000};
        int unsigned tempo_tab [8] = '{120, 120, 0, 511, 300, 20, 77, 19};
        int unsigned orig_tab [8] = '{120, 120, 1, 1023, 0, 1000, 90, 240};
        logic [31:0] len_tab [8] = '{400000, 3000000, 5000000, 32'hFFFF_FFFF,
                                     150000, 20000000, 0, 900000};
        int unsigned n_ev, r;
        longint unsigned span;
        t_cmd c;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle block with an empty store, then a short song.
        load_sorted(8, 200000);
        queue_cmd(noise_cmd(mepb_pkg::ACT_PLAY));
        queue_block(14'd64);
        c = noise_cmd(mepb_pkg::ACT_LOAD);
        c.slot = 10'h3FF; c.ev_us = '1; c.msg = '1; c.meta = 1'b1;
        queue_cmd(c);
        wait_idle();
        write_reg(mepb_pkg::REG_SONG_LENGTH, 200000);
        write_reg(mepb_pkg::REG_EVENT_COUNT, 8);
        queue_cmd(noise_cmd(mepb_pkg::ACT_PLAY));
        queue_block(14'd0);
        queue_block(14'd8192);
        queue_block(14'd16383);
        queue_cmd(noise_cmd(mepb_pkg::ACT_PAUSE));
        queue_block(14'd256);
        queue_cmd(noise_cmd(mepb_pkg::ACT_PLAY));
        queue_seek(17'h1FFFF);
        queue_seek(17'h10000);
        queue_seek(17'h00000);
        queue_seek(17'h08000);
        queue_block(14'd4096);
        queue_cmd(noise_cmd(mepb_pkg::ACT_STOP));
        queue_cmd(noise_cmd(ACT_SPARE_LO));
        queue_cmd(noise_cmd(ACT_SPARE_HI));
        queue_block(14'd100);
        wait_idle();

        // Random phases, each under its own register setting.
        for (int p = 0; p < 8; p++) begin
            calm_mode = (p % 3 == 2);
            if (p == 1) begin
                // Dense cluster at song start to push past the per-block limit.
                n_ev = 66;
                for (int unsigned k = 0; k < n_ev; k++)
                    queue_load(k, 64'(k) * 64'd20, 1'b0);
            end else begin
                n_ev = $urandom_range(4, 16);
                span = (len_tab[p] == 0) ? 64'hFFFF_FFFF : 64'(len_tab[p]);
                load_sorted(n_ev, span);
            end
            wait_idle();
            write_reg(mepb_pkg::REG_SAMPLE_RATE, rate_tab[p]);
            write_reg(mepb_pkg::REG_TEMPO_BPM, tempo_tab[p]);
            write_reg(mepb_pkg::REG_ORIGINAL_BPM, orig_tab[p]);
            write_reg(mepb_pkg::REG_SONG_LENGTH, len_tab[p]);
            write_reg(mepb_pkg::REG_LOOPING, 32'(p % 2));
            write_reg(mepb_pkg::REG_EVENT_COUNT, n_ev);

            queue_cmd(noise_cmd(mepb_pkg::ACT_PLAY));
            // a wide first block covers the whole cluster
            if (p == 1) queue_block(14'd1024);
            for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
                r = $urandom_range(99);
                if (r < 45) begin
                    queue_block(random_block_size());
                end else if (r < 57) begin
                    queue_cmd(noise_cmd(mepb_pkg::ACT_PLAY));
                end else if (r < 62) begin
                    queue_cmd(noise_cmd(mepb_pkg::ACT_PAUSE));
                end else if (r < 67) begin
                    queue_cmd(noise_cmd(mepb_pkg::ACT_STOP));
                end else if (r < 79) begin
                    queue_seek(($urandom_range(3) == 0) ? 17'($urandom) :
                               17'($urandom_range(65536)));
                end else if (r < 94) begin
                    // any slot; entries at or past the count are never read
                    queue_cmd(noise_cmd(mepb_pkg::ACT_LOAD));
                end else begin
                    queue_cmd(noise_cmd(($urandom_range(1) != 0) ? ACT_SPARE_LO
                                                                  : ACT_SPARE_HI));
                end
            end
            wait_idle();
        end

        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0 && expected_beats.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/mepb_pkg.sv
hdl/mepb_div.sv
hdl/midi_event_playback_scheduler.sv
tb/sv/tb_top.sv
